// ===== rtl/oqc_pkg.sv =====
// shared codes and controller/datapath interface types for the order queue
// no dependencies
package oqc_pkg;

  localparam logic [2:0] CMD_ADD     = 3'd0;
  localparam logic [2:0] CMD_LOOKUP  = 3'd1;
  localparam logic [2:0] CMD_FULFILL = 3'd2;
  localparam logic [2:0] CMD_CANCEL  = 3'd3;
  localparam logic [2:0] CMD_LIST    = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_HEAD      = 3'd4;

  localparam logic [47:0] SALES_MAX = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {PTR_HOLD, PTR_CLR, PTR_INC, PTR_NEXT} ptr_op_t;

  typedef enum logic [3:0] {
    RES_NONE, RES_ADD, RES_FULL, RES_EMPTY, RES_ZERO,
    RES_MISS, RES_FOUND, RES_HEAD, RES_REMOVED, RES_LIST
  } res_op_t;

  typedef struct packed {
    logic    latch;
    ptr_op_t ptr_op;
    res_op_t res_op;
    logic    hit;
    logic    shift_wr;
    logic    mul;
    logic    load;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       full;
    logic       empty;
    logic       match;
    logic       scan_end;
    logic       shift_done;
    logic       hit_head;
    logic       out_busy;
    logic       res_last;
  } dp_stat_t;

endpackage

// ===== rtl/oqc_ctrl.sv =====
// sequencer for the order queue: walks scans, compaction and list output
// depends on oqc_pkg
module oqc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  oqc_pkg::dp_stat_t stat,
  output oqc_pkg::dp_cmd_t  cmd_o
);
  import oqc_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DISPATCH, S_SCAN, S_SHIFT, S_LIST, S_MUL, S_LOAD}
    state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd_o      = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd_o.latch  = 1'b1;
          cmd_o.ptr_op = PTR_CLR;
          state_next   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.cmd) inside
          CMD_ADD: begin
            cmd_o.res_op = stat.full ? RES_FULL : RES_ADD;
            state_next   = S_MUL;
          end
          CMD_LOOKUP, CMD_FULFILL, CMD_CANCEL: begin
            if (stat.empty) begin
              cmd_o.res_op = RES_EMPTY;
              state_next   = S_MUL;
            end else begin
              cmd_o.ptr_op = PTR_INC;
              state_next   = S_SCAN;
            end
          end
          CMD_LIST: begin
            if (stat.empty) begin
              cmd_o.res_op = RES_EMPTY;
              state_next   = S_MUL;
            end else begin
              state_next = S_LIST;
            end
          end
          default: begin
            cmd_o.res_op = RES_ZERO;
            state_next   = S_MUL;
          end
        endcase
      end
      S_SCAN: begin
        cmd_o.ptr_op = PTR_INC;
        if (stat.match) begin
          if (stat.cmd == CMD_LOOKUP) begin
            cmd_o.res_op = RES_FOUND;
            state_next   = S_MUL;
          end else if (stat.cmd == CMD_CANCEL && stat.hit_head) begin
            cmd_o.res_op = RES_HEAD;
            state_next   = S_MUL;
          end else begin
            cmd_o.hit  = 1'b1;
            state_next = S_SHIFT;
          end
        end else if (stat.scan_end) begin
          cmd_o.res_op = RES_MISS;
          state_next   = S_MUL;
        end
      end
      S_SHIFT: begin
        cmd_o.ptr_op = PTR_INC;
        if (stat.shift_done) begin
          cmd_o.res_op = RES_REMOVED;
          state_next   = S_MUL;
        end else begin
          cmd_o.shift_wr = 1'b1;
        end
      end
      S_LIST: begin
        cmd_o.res_op = RES_LIST;
        cmd_o.ptr_op = PTR_NEXT;
        state_next   = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul  = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (!stat.out_busy) begin
          cmd_o.load = 1'b1;
          state_next = stat.res_last ? S_IDLE : S_LIST;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/oqc_dp.sv =====
// order queue datapath: entry memory, walk pointer, totals, result and output registers
// depends on oqc_pkg
module oqc_dp #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  oqc_pkg::dp_cmd_t  cmd_i,
  output oqc_pkg::dp_stat_t stat,
  input  logic [2:0]        cmd,
  input  logic [15:0]       order_id,
  input  logic [9:0]        quantity,
  input  logic [15:0]       unit_price,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        status,
  output logic [15:0]       result_id,
  output logic [9:0]        result_quantity,
  output logic [25:0]       amount,
  output logic [3:0]        position,
  output logic [4:0]        pending_count,
  output logic [13:0]       pending_quantity,
  output logic [47:0]       total_sales,
  output logic              last
);
  import oqc_pkg::*;

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int PW = CW + 1;

  logic [15:0] ids  [QUEUE_DEPTH];
  logic [9:0]  qtys [QUEUE_DEPTH];

  logic [2:0]  cmd_r;
  logic [15:0] key_r;
  logic [9:0]  qin_r;
  logic [CW-1:0] cnt;
  logic [15:0] last_id;
  logic [13:0] qsum;
  logic [47:0] sales;
  logic [PW-1:0] ptr, dptr, hit_idx;
  logic [15:0] rd_id, hit_id;
  logic [9:0]  rd_qty, hit_q;
  logic [2:0]  res_status;
  logic [15:0] res_id;
  logic [9:0]  res_q;
  logic [3:0]  res_pos;
  logic        res_last;
  logic [25:0] amount_r;
  logic [15:0] id_new;
  logic [47:0] sales_next;
  logic        sale;

  assign id_new = (last_id == 16'hFFFF) ? 16'd1 : last_id + 16'd1;
  assign sale   = (cmd_r == CMD_FULFILL) && (res_status == ST_OK);
  assign sales_next = !sale ? sales :
                      (sales > SALES_MAX - 48'(amount_r)) ? SALES_MAX : sales + 48'(amount_r);

  assign stat.cmd        = cmd_r;
  assign stat.full       = (cnt == CW'(QUEUE_DEPTH));
  assign stat.empty      = (cnt == '0);
  assign stat.match      = (cmd_r == CMD_FULFILL) || (rd_id == key_r);
  assign stat.scan_end   = ((dptr + PW'(1)) == PW'(cnt));
  assign stat.shift_done = (dptr >= PW'(cnt));
  assign stat.hit_head   = (dptr == '0);
  assign stat.out_busy   = out_valid && out_stall;
  assign stat.res_last   = res_last;

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    rd_id  <= ids[IW'(ptr)];
    rd_qty <= qtys[IW'(ptr)];
    if (cmd_i.res_op == RES_ADD) begin
      ids[IW'(cnt)]  <= id_new;
      qtys[IW'(cnt)] <= qin_r;
    end else if (cmd_i.shift_wr) begin
      ids[IW'(dptr - PW'(1))]  <= rd_id;
      qtys[IW'(dptr - PW'(1))] <= rd_qty;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    dptr <= ptr;
    if (cmd_i.latch) begin
      cmd_r <= cmd;
      key_r <= order_id;
      qin_r <= quantity;
    end
    if (cmd_i.hit) begin
      hit_idx <= dptr;
      hit_id  <= rd_id;
      hit_q   <= rd_qty;
    end
    if (cmd_i.mul) begin
      amount_r <= 26'(res_q) * 26'(unit_price);
    end
    case (cmd_i.res_op)
      RES_ADD: begin
        res_status <= ST_OK; res_id <= id_new; res_q <= qin_r;
        res_pos <= 4'(cnt); res_last <= 1'b1;
      end
      RES_FULL: begin
        res_status <= ST_FULL; res_id <= '0; res_q <= '0; res_pos <= '0; res_last <= 1'b1;
      end
      RES_EMPTY: begin
        res_status <= ST_EMPTY; res_id <= '0; res_q <= '0; res_pos <= '0; res_last <= 1'b1;
      end
      RES_ZERO: begin
        res_status <= ST_OK; res_id <= '0; res_q <= '0; res_pos <= '0; res_last <= 1'b1;
      end
      RES_MISS: begin
        res_status <= ST_NOT_FOUND; res_id <= '0; res_q <= '0; res_pos <= '0;
        res_last <= 1'b1;
      end
      RES_FOUND: begin
        res_status <= ST_OK; res_id <= key_r; res_q <= rd_qty;
        res_pos <= 4'(dptr); res_last <= 1'b1;
      end
      RES_HEAD: begin
        res_status <= ST_HEAD; res_id <= key_r; res_q <= rd_qty;
        res_pos <= '0; res_last <= 1'b1;
      end
      RES_REMOVED: begin
        res_status <= ST_OK; res_id <= hit_id; res_q <= hit_q;
        res_pos <= 4'(hit_idx); res_last <= 1'b1;
      end
      RES_LIST: begin
        res_status <= ST_OK; res_id <= rd_id; res_q <= rd_qty;
        res_pos <= 4'(dptr); res_last <= ((dptr + PW'(1)) == PW'(cnt));
      end
      default: ;
    endcase
    if (cmd_i.load) begin
      status           <= res_status;
      result_id        <= res_id;
      result_quantity  <= res_q;
      amount           <= amount_r;
      position         <= res_pos;
      pending_count    <= 5'(cnt);
      pending_quantity <= qsum;
      total_sales      <= sales_next;
      last             <= res_last;
    end
  end

  // control state and totals
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr       <= '0;
      cnt       <= '0;
      last_id   <= '0;
      qsum      <= '0;
      sales     <= '0;
      out_valid <= 1'b0;
    end else begin
      case (cmd_i.ptr_op)
        PTR_CLR:  ptr <= '0;
        PTR_INC:  ptr <= ptr + PW'(1);
        PTR_NEXT: ptr <= dptr + PW'(1);
        default:  ;
      endcase
      if (cmd_i.res_op == RES_ADD) begin
        cnt     <= cnt + CW'(1);
        last_id <= id_new;
        qsum    <= qsum + 14'(qin_r);
      end else if (cmd_i.res_op == RES_REMOVED) begin
        cnt <= cnt - CW'(1);
      end
      if (cmd_i.hit) begin
        qsum <= qsum - 14'(rd_qty);
      end
      if (cmd_i.load) begin
        sales     <= sales_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/order_queue_with_cancel.sv =====
// add, empty and unused codes go from accept through dispatch, multiply and load to the output
// lookup, cancel and fulfill walk the n entries (one entry a cycle) before multiply and load
// list: each emitted entry passes through list, multiply and load; one request is worked at a time
// throughput set by the scan/compaction walk over the entry memory
// reset: synchronous, clears count, totals, last number, price and output valid
// entry memory is not cleared; only entries below the count are read
module order_queue_with_cancel #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  cmd,
  input  logic [15:0] order_id,
  input  logic [9:0]  quantity,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [15:0] result_id,
  output logic [9:0]  result_quantity,
  output logic [25:0] amount,
  output logic [3:0]  position,
  output logic [4:0]  pending_count,
  output logic [13:0] pending_quantity,
  output logic [47:0] total_sales,
  output logic        last,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import oqc_pkg::*;

  dp_cmd_t  dcmd;
  dp_stat_t dstat;
  logic [15:0] unit_price;

  // single price register at offset zero
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {16'd0, unit_price} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_price <= '0;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      unit_price <= pwdata[15:0];
    end
  end

  // sequencer
  oqc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (dstat),
    .cmd_o    (dcmd)
  );

  // storage, arithmetic and output register
  oqc_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd_i            (dcmd),
    .stat             (dstat),
    .cmd              (cmd),
    .order_id         (order_id),
    .quantity         (quantity),
    .unit_price       (unit_price),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .result_id        (result_id),
    .result_quantity  (result_quantity),
    .amount           (amount),
    .position         (position),
    .pending_count    (pending_count),
    .pending_quantity (pending_quantity),
    .total_sales      (total_sales),
    .last             (last)
  );

endmodule

// ===== rtl/oqc_checker.sv =====
// port-level checks for the order queue, bound to the top level
// depends on oqc_pkg
module oqc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  status,
  input logic [15:0] result_id,
  input logic [9:0]  result_quantity,
  input logic [25:0] amount,
  input logic [4:0]  pending_count,
  input logic        last
);
  import oqc_pkg::*;

  // a taken request keeps the block busy for the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while not busy after");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_id) && $stable(status))
    else $error("stalled result changed");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> last)
    else $error("error result not marked last");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> pending_count == 5'd0 && result_id == 16'd0)
    else $error("empty status with entries");

  a_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_NOT_FOUND |-> amount == 26'd0 && result_quantity == 10'd0)
    else $error("miss result carries data");

endmodule

bind order_queue_with_cancel oqc_checker u_chk (.*);

// ===== tb/order_queue_with_cancel_test.sv =====
// self-checking testbench for order_queue_with_cancel: random and directed requests
// against a behavioral queue predictor, with random idling and stall pressure
// depends on rtl/oqc_pkg.sv and rtl/order_queue_with_cancel.sv
`timescale 1ns / 100ps

module order_queue_with_cancel_test;
  import oqc_pkg::*;

  localparam int DEPTH = 16;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [1:0] ADDR_UNIT_PRICE = 2'd0;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] order_id;
    logic [9:0]  quantity;
  } request_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] result_id;
    logic [9:0]  result_quantity;
    logic [25:0] amount;
    logic [3:0]  position;
    logic [4:0]  pending_count;
    logic [13:0] pending_quantity;
    logic [47:0] total_sales;
    logic        last;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] cmd = '0;
  logic [15:0] order_id = '0;
  logic [9:0] quantity = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] status;
  logic [15:0] result_id;
  logic [9:0] result_quantity;
  logic [25:0] amount;
  logic [3:0] position;
  logic [4:0] pending_count;
  logic [13:0] pending_quantity;
  logic [47:0] total_sales;
  logic last;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  order_queue_with_cancel #(.QUEUE_DEPTH(DEPTH)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .order_id(order_id), .quantity(quantity),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .result_id(result_id), .result_quantity(result_quantity),
    .amount(amount), .position(position), .pending_count(pending_count),
    .pending_quantity(pending_quantity), .total_sales(total_sales), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: mirror of the queue contents and running totals
  logic [15:0] queue_ids [DEPTH];
  logic [9:0]  queue_qty [DEPTH];
  int          queue_len = 0;
  logic [15:0] last_number = '0;
  logic [47:0] sales_sum = '0;
  logic [13:0] qty_sum = '0;
  logic [15:0] price = '0;

  request_t pending_requests[$];
  reply_t   expected_replies[$];
  int       error_count = 0;
  int       idle_cycles = 0;
  bit       hold_receiver = 1'b0;

  function automatic reply_t make_reply(logic [2:0] st, logic [15:0] id, logic [9:0] q,
                                        int pos, bit is_last);
    reply_t r;
    logic [41:0] product;
    product = q * price;
    r.status = st;
    r.result_id = id;
    r.result_quantity = q;
    r.amount = product[25:0];
    r.position = pos[3:0];
    r.pending_count = queue_len[4:0];
    r.pending_quantity = qty_sum;
    r.total_sales = sales_sum;
    r.last = is_last;
    return r;
  endfunction

  task automatic drop_entry(int idx);
    qty_sum = qty_sum - queue_qty[idx];
    for (int i = idx; i + 1 < queue_len; i++) begin
      queue_ids[i] = queue_ids[i + 1];
      queue_qty[i] = queue_qty[i + 1];
    end
    queue_len--;
  endtask

  // work out every reply that one accepted request causes
  task automatic predict_order_step(request_t req);
    int hit;
    logic [9:0] q;
    logic [15:0] id;
    logic [41:0] product;
    logic [48:0] sum;
    hit = -1;
    case (req.cmd)
      CMD_ADD: begin
        if (queue_len >= DEPTH) begin
          expected_replies.push_back(make_reply(ST_FULL, 0, 0, 0, 1));
        end else begin
          last_number = last_number + 16'd1;
          if (last_number == 0) last_number = 16'd1;
          queue_ids[queue_len] = last_number;
          queue_qty[queue_len] = req.quantity;
          queue_len++;
          qty_sum = qty_sum + req.quantity;
          expected_replies.push_back(make_reply(ST_OK, last_number, req.quantity,
                                                queue_len - 1, 1));
        end
      end
      CMD_LOOKUP, CMD_CANCEL: begin
        if (queue_len == 0) begin
          expected_replies.push_back(make_reply(ST_EMPTY, 0, 0, 0, 1));
        end else begin
          for (int i = queue_len - 1; i >= 0; i--)
            if (queue_ids[i] == req.order_id) hit = i;
          if (hit < 0) begin
            expected_replies.push_back(make_reply(ST_NOT_FOUND, 0, 0, 0, 1));
          end else begin
            q = queue_qty[hit];
            if (req.cmd == CMD_LOOKUP) begin
              expected_replies.push_back(make_reply(ST_OK, req.order_id, q, hit, 1));
            end else if (hit == 0) begin
              expected_replies.push_back(make_reply(ST_HEAD, req.order_id, q, 0, 1));
            end else begin
              drop_entry(hit);
              expected_replies.push_back(make_reply(ST_OK, req.order_id, q, hit, 1));
            end
          end
        end
      end
      CMD_FULFILL: begin
        if (queue_len == 0) begin
          expected_replies.push_back(make_reply(ST_EMPTY, 0, 0, 0, 1));
        end else begin
          id = queue_ids[0];
          q = queue_qty[0];
          drop_entry(0);
          product = q * price;
          sum = sales_sum + product[25:0];
          sales_sum = sum[48] ? SALES_MAX : sum[47:0];
          expected_replies.push_back(make_reply(ST_OK, id, q, 0, 1));
        end
      end
      CMD_LIST: begin
        if (queue_len == 0)
          expected_replies.push_back(make_reply(ST_EMPTY, 0, 0, 0, 1));
        else
          for (int i = 0; i < queue_len; i++)
            expected_replies.push_back(make_reply(ST_OK, queue_ids[i], queue_qty[i], i,
                                                  i == queue_len - 1));
      end
      default: expected_replies.push_back(make_reply(ST_OK, 0, 0, 0, 1));
    endcase
  endtask

  // driver: random gap before each request, payload held while stalled
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_order_step('{cmd, order_id, quantity});
        void'(pending_requests.pop_front());
        send_gap = $urandom_range(3) == 0 ? 0 : $urandom_range(7);
      end
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0 || pending_requests.size() == 0) begin
          in_valid <= 1'b0;
          if (send_gap > 0) send_gap--;
        end else begin
          in_valid <= 1'b1;
          cmd <= pending_requests[0].cmd;
          order_id <= pending_requests[0].order_id;
          quantity <= pending_requests[0].quantity;
        end
      end
    end
  end

  // monitor: compare each reply against the oldest prediction, random stall
  int recv_gap = 0;
  always @(posedge clk) begin
    reply_t exp_r;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_replies.size() == 0) begin
          $error("unexpected reply status=%0d id=%0d", status, result_id);
          error_count++;
        end else begin
          exp_r = expected_replies.pop_front();
          if (status !== exp_r.status) begin
            $error("status exp %0d got %0d", exp_r.status, status); error_count++; end
          if (result_id !== exp_r.result_id) begin
            $error("result_id exp %0d got %0d", exp_r.result_id, result_id);
            error_count++; end
          if (result_quantity !== exp_r.result_quantity) begin
            $error("result_quantity exp %0d got %0d", exp_r.result_quantity,
                   result_quantity); error_count++; end
          if (amount !== exp_r.amount) begin
            $error("amount exp %0d got %0d", exp_r.amount, amount); error_count++; end
          if (position !== exp_r.position) begin
            $error("position exp %0d got %0d", exp_r.position, position);
            error_count++; end
          if (pending_count !== exp_r.pending_count) begin
            $error("pending_count exp %0d got %0d", exp_r.pending_count, pending_count);
            error_count++; end
          if (pending_quantity !== exp_r.pending_quantity) begin
            $error("pending_quantity exp %0d got %0d", exp_r.pending_quantity,
                   pending_quantity); error_count++; end
          if (total_sales !== exp_r.total_sales) begin
            $error("total_sales exp %0d got %0d", exp_r.total_sales, total_sales);
            error_count++; end
          if (last !== exp_r.last) begin
            $error("last exp %0d got %0d", exp_r.last, last); error_count++; end
        end
        recv_gap = $urandom_range(3) == 0 ? 0 : $urandom_range(7);
      end
      if (hold_receiver) out_stall <= 1'b1;
      else if (recv_gap > 0) begin
        out_stall <= 1'b1;
        recv_gap--;
      end else out_stall <= 1'b0;
    end
  end

  // watchdog: cycles with no accepted request or reply
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("order_queue_with_cancel regression: fail");
      $finish;
    end
  end

  task automatic write_price(logic [15:0] value);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_UNIT_PRICE; pwdata <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    price = value;
  endtask

  task automatic push(logic [2:0] c, logic [15:0] id, logic [9:0] q);
    pending_requests.push_back('{c, id, q});
  endtask

  // block is idle once all requests are in and every reply is back
  task automatic drain();
    wait (pending_requests.size() == 0 && !in_valid && expected_replies.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  // random mix with content that mostly hits live numbers
  task automatic random_phase(int count);
    logic [15:0] id;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      id = (last_number > 16'd20 && $urandom_range(3) != 0) ?
           last_number - $urandom_range(20) : 16'($urandom);
      if ($urandom_range(3) == 0) id = 16'($urandom_range(last_number + 3));
      if (pick < 35) push(CMD_ADD, 16'($urandom), 10'($urandom));
      else if (pick < 50) push(CMD_LOOKUP, id, 10'($urandom));
      else if (pick < 65) push(CMD_CANCEL, id, 10'($urandom));
      else if (pick < 82) push(CMD_FULFILL, 16'($urandom), 10'($urandom));
      else if (pick < 95) push(CMD_LIST, 16'($urandom), 10'($urandom));
      else push(3'($urandom_range(7, 5)), 16'($urandom), 10'($urandom));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: empty queue cases, unused codes, field extremes
    write_price(16'hFFFF);
    push(CMD_LOOKUP, 16'd1, 10'd0);
    push(CMD_FULFILL, 16'd0, 10'd0);
    push(CMD_CANCEL, 16'hFFFF, 10'h3FF);
    push(CMD_LIST, 16'd0, 10'd0);
    push(3'd7, 16'hFFFF, 10'h3FF);
    push(CMD_ADD, 16'hFFFF, 10'h3FF);
    push(CMD_ADD, 16'd0, 10'd0);
    push(CMD_ADD, 16'd0, 10'd512);
    push(CMD_LOOKUP, 16'd3, 10'd0);
    push(CMD_LOOKUP, 16'd99, 10'd0);
    push(CMD_CANCEL, 16'd1, 10'd0);
    push(CMD_CANCEL, 16'd2, 10'd0);
    push(CMD_CANCEL, 16'd0, 10'd0);
    push(CMD_LIST, 16'd0, 10'd0);
    push(CMD_FULFILL, 16'd0, 10'd0);
    push(3'd5, 16'd0, 10'd0);
    // fill past full under receiver hold-off so the input backs up
    for (int i = 0; i < 17; i++) push(CMD_ADD, 16'd0, 10'($urandom));
    push(CMD_LIST, 16'd0, 10'd0);
    fork
      begin
        hold_receiver = 1'b1;
        repeat (400) @(posedge clk);
        hold_receiver = 1'b0;
      end
    join_none
    drain();

    // price sweep: zero, random and unit price over random mixes
    write_price(16'd0);
    random_phase(40);
    drain();
    write_price(16'($urandom));
    random_phase(46);
    drain();
    write_price(16'd1);
    random_phase(60);
    drain();

    if (error_count == 0) $display("order_queue_with_cancel regression: pass");
    else $display("order_queue_with_cancel regression: fail");
    $finish;
  end

endmodule
